FILE: src/rtfb_pkg.sv
// shared types, constants and helpers for the framebuffer pixel writer
`default_nettype none

package rtfb_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_SCREEN_EXTENT  = 3'd0;
   localparam logic [2:0] REG_LINE_BYTES     = 3'd1;
   localparam logic [2:0] REG_PIXEL_BITS     = 3'd2;
   localparam logic [2:0] REG_MEMORY_BYTES   = 3'd3;
   localparam logic [2:0] REG_RED_LAYOUT     = 3'd4;
   localparam logic [2:0] REG_GREEN_LAYOUT   = 3'd5;
   localparam logic [2:0] REG_BLUE_LAYOUT    = 3'd6;
   localparam logic [2:0] REG_ALPHA_LAYOUT   = 3'd7;

   // reset values
   localparam logic [31:0] RST_SCREEN_EXTENT  = 32'd31458560;
   localparam logic [17:0] RST_LINE_BYTES     = 18'd2560;
   localparam logic [7:0]  RST_PIXEL_BITS     = 8'd32;
   localparam logic [31:0] RST_MEMORY_BYTES   = 32'd1228800;
   localparam logic [10:0] RST_RED_LAYOUT     = 11'd1032;
   localparam logic [10:0] RST_GREEN_LAYOUT   = 11'd520;
   localparam logic [10:0] RST_BLUE_LAYOUT    = 11'd8;
   localparam logic [10:0] RST_ALPHA_LAYOUT   = 11'd0;

   // rounding bias and ceil(2^32 / 255), exact for dividends below 2^24
   localparam logic [23:0] ROUND_BIAS = 24'd127;
   localparam logic [24:0] RECIP_255  = 25'd16843010;
   localparam logic [5:0]  MAX_LEN    = 6'd16;

   // supported bytes per pixel
   localparam logic [4:0] BPP_TWO   = 5'd2;
   localparam logic [4:0] BPP_THREE = 5'd3;
   localparam logic [4:0] BPP_FOUR  = 5'd4;

   typedef struct packed {
      logic [31:0] screen_extent;
      logic [17:0] line_bytes;
      logic [7:0]  pixel_bits;
      logic [31:0] memory_bytes;
      logic [10:0] red_layout;
      logic [10:0] green_layout;
      logic [10:0] blue_layout;
      logic [10:0] alpha_layout;
   } cfg_type;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic adv1;
      logic adv2;
   } stage_adv_type;

   // all-ones value of a field, length saturated at sixteen
   function automatic logic [15:0] field_top(input logic [10:0] layout);
      logic [5:0]  len;
      logic [16:0] pow;
      len = (layout[5:0] > MAX_LEN) ? MAX_LEN : layout[5:0];
      pow = 17'd1 << len[4:0];
      return 16'(pow - 17'd1);
   endfunction

   function automatic logic [4:0] field_off(input logic [10:0] layout);
      return layout[10:6];
   endfunction

endpackage

`default_nettype wire

FILE: src/rtfb_req_if.sv
// request channel: pixel coordinate and color word
`default_nettype none

interface rtfb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [7:0]         red_in;
   logic [7:0]         green_in;
   logic [7:0]         blue_in;

   modport source (output valid, pos_x, pos_y, red_in, green_in, blue_in, input ready);
   modport sink (input valid, pos_x, pos_y, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

FILE: src/rtfb_rsp_if.sv
// response channel: framebuffer write command
`default_nettype none

interface rtfb_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [31:0] byte_address;
   logic [31:0] pixel_word;
   logic [2:0]  byte_count;

   modport source (output valid, write_enable, byte_address, pixel_word, byte_count,
                   input ready);
   modport sink (input valid, write_enable, byte_address, pixel_word, byte_count,
                 output ready);
endinterface

`default_nettype wire

FILE: src/rtfb_scale.sv
// two-stage channel rescale: v * (2^len - 1) then rounded divide by 255
`default_nettype none

module rtfb_scale (
   input  wire logic                   clock,
   input  wire rtfb_pkg::stage_adv_type adv,
   input  wire logic [7:0]             value,
   input  wire logic [10:0]            layout,
   output logic [15:0]                 scaled
);

   logic [23:0] prod_ff;
   logic [23:0] prod_in;
   logic [15:0] scaled_ff;
   logic [15:0] scaled_in;
   logic [23:0] dividend;
   logic [48:0] recip_prod;

   // stage 1: scale up to the field range
   always_comb begin
      prod_in = 24'(value) * 24'(rtfb_pkg::field_top(layout));
   end

   // stage 2: divide by 255 through the reciprocal
   always_comb begin
      dividend   = prod_ff + rtfb_pkg::ROUND_BIAS;
      recip_prod = 49'(dividend) * 49'(rtfb_pkg::RECIP_255);
      scaled_in  = recip_prod[47:32];
   end

   always_ff @(posedge clock) begin
      if (adv.adv1) begin
         prod_ff <= prod_in;
      end
      if (adv.adv2) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire

FILE: src/rtfb_addr.sv
// two-stage address path: screen checks, row and column products, sum
`default_nettype none

module rtfb_addr (
   input  wire logic                    clock,
   input  wire rtfb_pkg::stage_adv_type adv,
   input  wire rtfb_pkg::cfg_type       cfg,
   input  wire logic signed [15:0]      pos_x,
   input  wire logic signed [15:0]      pos_y,
   output logic                         pixel_ok,
   output logic [33:0]                  address,
   output logic [2:0]                   bytes
);

   logic [4:0]  bpp;
   logic        bpp_ok;
   logic        x_ok;
   logic        y_ok;

   logic        ok1_ff,    ok1_in;
   logic [32:0] row_ff,    row_in;
   logic [17:0] col_ff,    col_in;
   logic [2:0]  bytes1_ff, bytes1_in;

   logic        ok2_ff;
   logic [33:0] addr_ff,   addr_in;
   logic [2:0]  bytes2_ff;

   // stage 1: bounds and format checks, partial offsets
   always_comb begin
      bpp    = cfg.pixel_bits[7:3];
      bpp_ok = (bpp == rtfb_pkg::BPP_TWO) || (bpp == rtfb_pkg::BPP_THREE) ||
               (bpp == rtfb_pkg::BPP_FOUR);
      x_ok   = !pos_x[15] && ({1'b0, pos_x[14:0]} < cfg.screen_extent[15:0]);
      y_ok   = !pos_y[15] && ({1'b0, pos_y[14:0]} < cfg.screen_extent[31:16]);
      ok1_in    = x_ok && y_ok && bpp_ok;
      row_in    = 33'(pos_y[14:0]) * 33'(cfg.line_bytes);
      col_in    = 18'(pos_x[14:0]) * 18'(bpp[2:0]);
      bytes1_in = bpp[2:0];
   end

   // stage 2: full byte offset, no wrap
   always_comb begin
      addr_in = 34'(row_ff) + 34'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.adv1) begin
         ok1_ff    <= ok1_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         bytes1_ff <= bytes1_in;
      end
      if (adv.adv2) begin
         ok2_ff    <= ok1_ff;
         addr_ff   <= addr_in;
         bytes2_ff <= bytes1_ff;
      end
   end

   assign pixel_ok = ok2_ff;
   assign address  = addr_ff;
   assign bytes    = bytes2_ff;

endmodule

`default_nettype wire

FILE: src/rgb_to_framebuffer_pixel_writer.sv
// top level: config registers, pipeline control and final pack stage
`default_nettype none

// Converts an RGB888 pixel and coordinate into one packed framebuffer write.
// Accepts one word per clock while the response side does not stall, and
// returns one result word for every request through a three-stage pipeline
// (field scale multiply, reciprocal divide multiply with address sum, then
// pack, overrun check and output register). Stalls on the response side hold
// the pipeline without loss, and empty stages keep filling while it is held.
// Dropped writes come back with all fields zero. The user must write registers
// through csr_ only while no request is in flight; the block does not check.

module rgb_to_framebuffer_pixel_writer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   rtfb_req_if.sink         req_chan,
   rtfb_rsp_if.source       rsp_chan
);

   rtfb_pkg::cfg_type       cfg_ff;
   rtfb_pkg::stage_adv_type adv;

   logic        v1_ff, v2_ff, v3_ff;
   logic        adv3;

   logic [15:0] red_q, green_q, blue_q;
   logic        pixel_ok;
   logic [33:0] address;
   logic [2:0]  bytes;

   logic        fits;
   logic        we_in;
   logic [31:0] pixel_in;
   logic [31:0] alpha_mask;

   logic        we_ff;
   logic [31:0] addr_ff;
   logic [31:0] pixel_ff;
   logic [2:0]  count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_extent  <= rtfb_pkg::RST_SCREEN_EXTENT;
         cfg_ff.line_bytes     <= rtfb_pkg::RST_LINE_BYTES;
         cfg_ff.pixel_bits     <= rtfb_pkg::RST_PIXEL_BITS;
         cfg_ff.memory_bytes   <= rtfb_pkg::RST_MEMORY_BYTES;
         cfg_ff.red_layout     <= rtfb_pkg::RST_RED_LAYOUT;
         cfg_ff.green_layout   <= rtfb_pkg::RST_GREEN_LAYOUT;
         cfg_ff.blue_layout    <= rtfb_pkg::RST_BLUE_LAYOUT;
         cfg_ff.alpha_layout   <= rtfb_pkg::RST_ALPHA_LAYOUT;
      end else if (csr_write_enable) begin
         case (csr_index)
            rtfb_pkg::REG_SCREEN_EXTENT:  cfg_ff.screen_extent  <= csr_data;
            rtfb_pkg::REG_LINE_BYTES:     cfg_ff.line_bytes     <= csr_data[17:0];
            rtfb_pkg::REG_PIXEL_BITS:     cfg_ff.pixel_bits     <= csr_data[7:0];
            rtfb_pkg::REG_MEMORY_BYTES:   cfg_ff.memory_bytes   <= csr_data;
            rtfb_pkg::REG_RED_LAYOUT:     cfg_ff.red_layout     <= csr_data[10:0];
            rtfb_pkg::REG_GREEN_LAYOUT:   cfg_ff.green_layout   <= csr_data[10:0];
            rtfb_pkg::REG_BLUE_LAYOUT:    cfg_ff.blue_layout    <= csr_data[10:0];
            rtfb_pkg::REG_ALPHA_LAYOUT:   cfg_ff.alpha_layout   <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      adv3     = !v3_ff || rsp_chan.ready;
      adv.adv2 = !v2_ff || adv3;
      adv.adv1 = !v1_ff || adv.adv2;
   end

   assign req_chan.ready = adv.adv1;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv.adv1) begin
            v1_ff <= req_chan.valid;
         end
         if (adv.adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   rtfb_scale u_red (
      .clock  (clock),
      .adv    (adv),
      .value  (req_chan.red_in),
      .layout (cfg_ff.red_layout),
      .scaled (red_q)
   );

   rtfb_scale u_green (
      .clock  (clock),
      .adv    (adv),
      .value  (req_chan.green_in),
      .layout (cfg_ff.green_layout),
      .scaled (green_q)
   );

   rtfb_scale u_blue (
      .clock  (clock),
      .adv    (adv),
      .value  (req_chan.blue_in),
      .layout (cfg_ff.blue_layout),
      .scaled (blue_q)
   );

   rtfb_addr u_addr (
      .clock    (clock),
      .adv      (adv),
      .cfg      (cfg_ff),
      .pos_x    (req_chan.pos_x),
      .pos_y    (req_chan.pos_y),
      .pixel_ok (pixel_ok),
      .address  (address),
      .bytes    (bytes)
   );

   // stage 3: place fields, add alpha, check memory overrun
   always_comb begin
      if (cfg_ff.alpha_layout[5:0] != 6'd0) begin
         alpha_mask = 32'(rtfb_pkg::field_top(cfg_ff.alpha_layout))
                      << rtfb_pkg::field_off(cfg_ff.alpha_layout);
      end else begin
         alpha_mask = 32'd0;
      end
      pixel_in = (32'(red_q) << rtfb_pkg::field_off(cfg_ff.red_layout)) |
                 (32'(green_q) << rtfb_pkg::field_off(cfg_ff.green_layout)) |
                 (32'(blue_q) << rtfb_pkg::field_off(cfg_ff.blue_layout)) |
                 alpha_mask;
      fits  = (35'(address) + 35'(bytes)) <= 35'(cfg_ff.memory_bytes);
      we_in = pixel_ok && fits;
   end

   // output register, dropped writes read all zero
   always_ff @(posedge clock) begin
      if (adv3) begin
         we_ff    <= we_in;
         addr_ff  <= we_in ? address[31:0] : 32'd0;
         pixel_ff <= we_in ? pixel_in : 32'd0;
         count_ff <= we_in ? bytes : 3'd0;
      end
   end

   assign rsp_chan.valid        = v3_ff;
   assign rsp_chan.write_enable = we_ff;
   assign rsp_chan.byte_address = addr_ff;
   assign rsp_chan.pixel_word   = pixel_ff;
   assign rsp_chan.byte_count   = count_ff;

endmodule

`default_nettype wire

FILE: tb/fb_write_checker.sv
// checker for the pixel writer: tracks registers, predicts each write word and compares

module fb_write_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [7:0]         req_red_in,
   input  wire logic [7:0]         req_green_in,
   input  wire logic [7:0]         req_blue_in,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_write_enable,
   input  wire logic [31:0]        rsp_byte_address,
   input  wire logic [31:0]        rsp_pixel_word,
   input  wire logic [2:0]         rsp_byte_count,
   output int                      fail_count,
   output int                      pending_count
);

   localparam logic [31:0] ROUND_HALF     = 32'd127;
   localparam logic [31:0] FULL_SCALE     = 32'd255;
   localparam logic [7:0]  FULL_INTENSITY = 8'd255;

   typedef struct packed {
      logic        write_enable;
      logic [31:0] byte_address;
      logic [31:0] pixel_word;
      logic [2:0]  byte_count;
   } fb_write_type;

   rtfb_pkg::cfg_type active_cfg;
   fb_write_type      expected_writes[$];
   fb_write_type      oldest_write;
   int                failures = 0;

   // rescale one 8-bit level to the field length and move it to the field offset
   function automatic logic [31:0] scaled_field(input logic [7:0] level,
                                                input logic [10:0] layout);
      logic [5:0]  len;
      logic [31:0] span;
      logic [31:0] scaled;
      len = (layout[5:0] > rtfb_pkg::MAX_LEN) ? rtfb_pkg::MAX_LEN : layout[5:0];
      if (len == 6'd0)
         return 32'd0;
      span = (32'd1 << len) - 32'd1;
      scaled = (32'(level) * span + ROUND_HALF) / FULL_SCALE;
      // bits pushed past bit 31 fall off here
      return scaled << layout[10:6];
   endfunction

   // framebuffer write expected for one pixel under the given registers
   function automatic fb_write_type predict_write(input rtfb_pkg::cfg_type cfg,
                                                  input logic [15:0] x, y,
                                                  input logic [7:0] r, g, b);
      fb_write_type     w;
      logic [15:0]      width;
      logic [15:0]      height;
      logic [4:0]       bytes;
      logic [63:0]      addr;
      w = '0;
      width = cfg.screen_extent[15:0];
      height = cfg.screen_extent[31:16];
      bytes = cfg.pixel_bits[7:3];
      if (x[15] || y[15] || x >= width || y >= height)
         return w;
      if (bytes != rtfb_pkg::BPP_TWO && bytes != rtfb_pkg::BPP_THREE &&
          bytes != rtfb_pkg::BPP_FOUR)
         return w;
      // exact address, no wrap at 32 bits
      addr = 64'(y) * 64'(cfg.line_bytes) + 64'(x) * 64'(bytes);
      if (addr + 64'(bytes) > 64'(cfg.memory_bytes))
         return w;
      w.write_enable = 1'b1;
      w.byte_address = addr[31:0];
      w.pixel_word = scaled_field(r, cfg.red_layout) | scaled_field(g, cfg.green_layout)
                   | scaled_field(b, cfg.blue_layout);
      if (cfg.alpha_layout[5:0] != 6'd0)
         w.pixel_word |= scaled_field(FULL_INTENSITY, cfg.alpha_layout);
      w.byte_count = bytes[2:0];
      return w;
   endfunction

   task automatic report_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_writes.delete();
         active_cfg = '{rtfb_pkg::RST_SCREEN_EXTENT, rtfb_pkg::RST_LINE_BYTES,
                        rtfb_pkg::RST_PIXEL_BITS, rtfb_pkg::RST_MEMORY_BYTES,
                        rtfb_pkg::RST_RED_LAYOUT, rtfb_pkg::RST_GREEN_LAYOUT,
                        rtfb_pkg::RST_BLUE_LAYOUT, rtfb_pkg::RST_ALPHA_LAYOUT};
      end else begin
         // returned word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected write word, expected none, got %b %h %h %0d",
                        $time, rsp_write_enable, rsp_byte_address, rsp_pixel_word,
                        rsp_byte_count);
               failures++;
            end else begin
               oldest_write = expected_writes.pop_front();
               report_field("write_enable", 32'(oldest_write.write_enable),
                            32'(rsp_write_enable));
               report_field("byte_address", oldest_write.byte_address, rsp_byte_address);
               report_field("pixel_word", oldest_write.pixel_word, rsp_pixel_word);
               report_field("byte_count", 32'(oldest_write.byte_count),
                            32'(rsp_byte_count));
            end
         end
         // prediction for each accepted pixel
         if (req_valid && req_ready)
            expected_writes.push_back(predict_write(active_cfg, req_pos_x, req_pos_y,
                                                    req_red_in, req_green_in,
                                                    req_blue_in));
         // register shadow
         if (csr_write_enable) begin
            case (csr_index)
               rtfb_pkg::REG_SCREEN_EXTENT: active_cfg.screen_extent = csr_data;
               rtfb_pkg::REG_LINE_BYTES:    active_cfg.line_bytes = csr_data[17:0];
               rtfb_pkg::REG_PIXEL_BITS:    active_cfg.pixel_bits = csr_data[7:0];
               rtfb_pkg::REG_MEMORY_BYTES:  active_cfg.memory_bytes = csr_data;
               rtfb_pkg::REG_RED_LAYOUT:    active_cfg.red_layout = csr_data[10:0];
               rtfb_pkg::REG_GREEN_LAYOUT:  active_cfg.green_layout = csr_data[10:0];
               rtfb_pkg::REG_BLUE_LAYOUT:   active_cfg.blue_layout = csr_data[10:0];
               rtfb_pkg::REG_ALPHA_LAYOUT:  active_cfg.alpha_layout = csr_data[10:0];
               default: ;
            endcase
         end
      end
      fail_count <= failures;
      pending_count <= expected_writes.size();
   end

endmodule

FILE: tb/rgb_to_framebuffer_pixel_writer_tb.sv
// testbench top: stimulus, register phases, stall control and verdict

module rgb_to_framebuffer_pixel_writer_tb;

   localparam int PIPE_LATENCY    = 3;
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASE_COUNT     = 12;
   localparam int WORDS_PER_PHASE = 150;
   localparam int HOLD_PHASE      = 5;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [2:0]        csr_index;
   logic [31:0]       csr_data;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                stall_cycles;
   int                fail_count;
   int                pending_count;
   rtfb_pkg::cfg_type fb_cfg;

   rtfb_req_if req_chan ();
   rtfb_rsp_if rsp_chan ();

   rgb_to_framebuffer_pixel_writer u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   fb_write_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_pos_x        (req_chan.pos_x),
      .req_pos_y        (req_chan.pos_y),
      .req_red_in       (req_chan.red_in),
      .req_green_in     (req_chan.green_in),
      .req_blue_in      (req_chan.blue_in),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_write_enable (rsp_chan.write_enable),
      .rsp_byte_address (rsp_chan.byte_address),
      .rsp_pixel_word   (rsp_chan.pixel_word),
      .rsp_byte_count   (rsp_chan.byte_count),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // write side back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one pixel word, with random idle cycles ahead of it
   task automatic send_word(input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= x;
      req_chan.pos_y <= y;
      req_chan.red_in <= r;
      req_chan.green_in <= g;
      req_chan.blue_in <= b;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // stop sending and let every predicted write come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input rtfb_pkg::cfg_type c);
      drain();
      csr_write(rtfb_pkg::REG_SCREEN_EXTENT, c.screen_extent);
      csr_write(rtfb_pkg::REG_LINE_BYTES, 32'(c.line_bytes));
      csr_write(rtfb_pkg::REG_PIXEL_BITS, 32'(c.pixel_bits));
      csr_write(rtfb_pkg::REG_MEMORY_BYTES, c.memory_bytes);
      csr_write(rtfb_pkg::REG_RED_LAYOUT, 32'(c.red_layout));
      csr_write(rtfb_pkg::REG_GREEN_LAYOUT, 32'(c.green_layout));
      csr_write(rtfb_pkg::REG_BLUE_LAYOUT, 32'(c.blue_layout));
      csr_write(rtfb_pkg::REG_ALPHA_LAYOUT, 32'(c.alpha_layout));
      csr_write_enable <= 1'b0;
      fb_cfg = c;
   endtask

   // mostly on screen, some at the edge, some anywhere including negative
   function automatic logic [15:0] pick_coord(input logic [15:0] extent);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70 && extent != 16'd0)
         return 16'($urandom_range(0, extent - 16'd1));
      if (sel < 85)
         return extent + 16'($urandom_range(0, 2)) - 16'd1;
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_level();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return 8'd0;
      if (sel == 1)
         return 8'd255;
      return 8'($urandom);
   endfunction

   // half anywhere in range, half a plausible offset and length
   function automatic logic [10:0] pick_layout();
      if ($urandom_range(0, 1) == 0)
         return 11'($urandom_range(0, 2000));
      return {5'($urandom_range(0, 24)), 6'($urandom_range(0, 16))};
   endfunction

   // register set for one random phase, the first three pinned to extremes
   function automatic rtfb_pkg::cfg_type pick_config(input int phase);
      rtfb_pkg::cfg_type c;
      int                w;
      int                h;
      int                bytes;
      logic [63:0]       span;
      w = $urandom_range(1, 1024);
      h = $urandom_range(1, 768);
      case ($urandom_range(0, 5))
         0:       c.pixel_bits = 8'd16;
         1:       c.pixel_bits = 8'd24;
         2:       c.pixel_bits = 8'd32;
         3:       c.pixel_bits = 8'd23;
         4:       c.pixel_bits = 8'd31;
         default: c.pixel_bits = 8'($urandom);
      endcase
      bytes = c.pixel_bits / 8;
      if (bytes == 0)
         bytes = 1;
      c.screen_extent = {16'(h), 16'(w)};
      if ($urandom_range(0, 9) == 0)
         c.screen_extent = $urandom;
      c.line_bytes = 18'(w * bytes + $urandom_range(0, 32));
      if ($urandom_range(0, 9) == 0)
         c.line_bytes = 18'($urandom);
      // memory ends within a few bytes of the last pixel
      span = 64'(c.line_bytes) * 64'(h - 1) + 64'(w * bytes) + 64'($urandom_range(0, 8));
      c.memory_bytes = 32'(span - 64'd4);
      if ($urandom_range(0, 9) == 0)
         c.memory_bytes = $urandom;
      c.red_layout = pick_layout();
      c.green_layout = pick_layout();
      c.blue_layout = pick_layout();
      c.alpha_layout = ($urandom_range(0, 1) == 0) ? 11'd0 : pick_layout();
      case (phase)
         0: c = '{'1, '1, 8'd32, '1, 11'd2000, 11'd63, 11'd0, 11'd1983};
         1: begin
            c.line_bytes = '0;
            c.memory_bytes = '0;
         end
         2: c = '0;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      rtfb_pkg::cfg_type c;
      int                phase;
      int                n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = rtfb_pkg::REG_SCREEN_EXTENT;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 67;
      fb_cfg = '{rtfb_pkg::RST_SCREEN_EXTENT, rtfb_pkg::RST_LINE_BYTES,
                 rtfb_pkg::RST_PIXEL_BITS, rtfb_pkg::RST_MEMORY_BYTES,
                 rtfb_pkg::RST_RED_LAYOUT, rtfb_pkg::RST_GREEN_LAYOUT,
                 rtfb_pkg::RST_BLUE_LAYOUT, rtfb_pkg::RST_ALPHA_LAYOUT};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default 1280x480 layout: corners, edges, negatives, last pixel fits exactly
      send_word(16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
      send_word(16'd0, 16'd0, 8'd255, 8'd255, 8'd255);
      send_word(16'd639, 16'd479, 8'd255, 8'd0, 8'd128);
      send_word(16'd640, 16'd0, 8'd10, 8'd20, 8'd30);
      send_word(16'd0, 16'd480, 8'd10, 8'd20, 8'd30);
      send_word(16'hFFFF, 16'd0, 8'd1, 8'd2, 8'd3);
      send_word(16'd0, 16'h8000, 8'd1, 8'd2, 8'd3);
      send_word(16'h7FFF, 16'h7FFF, 8'd4, 8'd5, 8'd6);
      send_word(16'd100, 16'd200, 8'd1, 8'd254, 8'd127);
      send_word(16'd639, 16'd0, 8'd128, 8'd127, 8'd129);

      // full extents: red pushed past bit 31, green length saturates,
      // blue has zero length, alpha present, addresses around the 32-bit limit
      c = '{'1, '1, 8'd24, '1, 11'(30 * 64 + 16), 11'd63, 11'd0, 11'(24 * 64 + 8)};
      set_config(c);
      send_word(16'd5460, 16'd16384, 8'd255, 8'd255, 8'd0);
      send_word(16'd5461, 16'd16384, 8'd255, 8'd255, 8'd0);
      send_word(16'd0, 16'd16383, 8'd128, 8'd64, 8'd32);
      send_word(16'h7FFF, 16'd0, 8'd200, 8'd100, 8'd50);

      // unsupported pixel sizes and an empty screen
      c.pixel_bits = 8'd8;
      set_config(c);
      send_word(16'd0, 16'd0, 8'd9, 8'd9, 8'd9);
      c.pixel_bits = 8'd40;
      set_config(c);
      send_word(16'd1, 16'd1, 8'd9, 8'd9, 8'd9);
      c.pixel_bits = 8'd16;
      c.screen_extent = '0;
      set_config(c);
      send_word(16'd0, 16'd0, 8'd9, 8'd9, 8'd9);

      // rgb565 at 320x240, memory ends at the last pixel
      c = '{32'h00F0_0140, 18'd640, 8'd16, 32'd153600, 11'(11 * 64 + 5), 11'(5 * 64 + 6),
            11'd5, 11'd0};
      set_config(c);
      send_word(16'd319, 16'd239, 8'd255, 8'd255, 8'd255);
      send_word(16'd1, 16'd1, 8'd77, 8'd150, 8'd29);

      // random phases, each with its own register set
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT / 3) begin
            send_idle_pct = 67;
            recv_idle_pct = 16;
         end
         if (phase == 2 * PHASE_COUNT / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_config(pick_config(phase));
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            // hold off mid-phase until the pipeline is empty
            if (phase == HOLD_PHASE && n == WORDS_PER_PHASE / 2)
               drain();
            send_word(pick_coord(fb_cfg.screen_extent[15:0]),
                      pick_coord(fb_cfg.screen_extent[31:16]),
                      pick_level(), pick_level(), pick_level());
         end
      end

      drain();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
src/rtfb_pkg.sv
src/rtfb_req_if.sv
src/rtfb_rsp_if.sv
src/rtfb_scale.sv
src/rtfb_addr.sv
src/rgb_to_framebuffer_pixel_writer.sv
tb/fb_write_checker.sv
tb/rgb_to_framebuffer_pixel_writer_tb.sv
